[hw/rtl/bpg_pkg.sv]
// Shared types and constants of the beep pattern generator.
package bpg_pkg;

  // Item kinds carried on the input tuser.
  typedef logic [1:0] bpg_mode_t;
  localparam bpg_mode_t MODE_TICK       = 2'd0;
  localparam bpg_mode_t MODE_PLAY_COUNT = 2'd1;
  localparam bpg_mode_t MODE_PLAY_SL    = 2'd2;
  localparam bpg_mode_t MODE_UNUSED     = 2'd3;

  // Field widths.
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned PHASES_W = 6;
  localparam int unsigned SMODE_W  = 2;

  typedef logic [COUNT_W-1:0]  bpg_count_t;
  typedef logic [MS_W-1:0]     bpg_ms_t;
  typedef logic [PHASES_W-1:0] bpg_phases_t;

  // Timing constants in milliseconds.
  localparam bpg_ms_t SHORT_PHASE_MS   = 16'd150;
  localparam bpg_ms_t LONG_PHASE_MS    = 16'd800;
  localparam bpg_ms_t DEFAULT_PHASE_MS = 16'd300;
  localparam bpg_ms_t ELAPSED_MAX      = 16'hFFFF;

  // The short-long pattern has three timed phases: a short on, a short off, then a long on.
  localparam bpg_phases_t SL_PHASES_START = 6'd3;

  // Sound mode after reset.
  localparam logic [SMODE_W-1:0] SMODE_RESET = 2'd2;

  // Buffered input word.
  typedef struct packed {
    bpg_mode_t  mode;
    bpg_count_t beep_count;
    bpg_ms_t    phase_ms;
  } bpg_item_t;

endpackage

[hw/rtl/beep_pattern_generator.sv]
// Buzzer pattern generator: tick and play commands in, buzzer and busy state out.
//
// Usage:
// - The input stream (s_axis_*) carries one word per tick or command. tuser holds the
//   kind: 0 is a one-millisecond tick, 1 a counted play, 2 the short-long pattern,
//   3 is ignored. tdata holds beep_count and phase_ms for a counted play.
// - The output stream (m_axis_*) returns exactly one word per input word, holding the
//   buzzer and busy state after that word has been applied.
// - sound_mode is to be written through sound_mode_we/sound_mode_wdata while the block is
//   idle; the block does not enforce it. Zero mutes the block, ignoring play commands.
// Timing:
// - An accepted word passes through the input register, then the state update, which
//   loads the output register that drives m_axis.
// - Throughput is one word per cycle unless the receiver stalls; the state update is a
//   single pass of a 16-bit increment, compare and mux.
// - When the receiver stalls, the output register holds its word and the input
//   register fills; s_axis_tready drops only when both are full.
// Reset (rst, synchronous) clears both registers, silences the buzzer, sets the
// phase length to 300 ms and sound_mode to 2.
module beep_pattern_generator
  import bpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration register.
  input  logic               sound_mode_we,
  input  logic [SMODE_W-1:0] sound_mode_wdata,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [4:0] beep_count, [20:5] phase_ms, rest zero
  input  logic [1:0]         s_axis_tuser,  // [1:0] mode
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // [0] buzzer_on, [1] busy_res, rest zero
);

  // Configuration and pattern state.
  logic [SMODE_W-1:0] sound_mode;
  bpg_phases_t        phases_left, phases_left_next;
  bpg_ms_t            elapsed_ms, elapsed_ms_next;
  logic               sounding, sounding_next;
  bpg_ms_t            phase_length, phase_length_next;
  logic               short_long_pattern, short_long_pattern_next;

  // Pipeline registers.
  logic      item_valid;
  bpg_item_t item;
  logic      out_valid;
  logic      out_buzzer, out_busy;

  logic    item_advance;
  bpg_ms_t cur_len;
  bpg_ms_t elapsed_inc;
  logic    play_ok;

  assign item_advance  = item_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || item_advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_busy, out_buzzer};

  // Sound mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_mode <= SMODE_RESET;
    end else if (sound_mode_we) begin
      sound_mode <= sound_mode_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.mode       <= s_axis_tuser;
      item.beep_count <= s_axis_tdata[COUNT_W-1:0];
      item.phase_ms   <= s_axis_tdata[COUNT_W+MS_W-1:COUNT_W];
    end
  end

  // Length of the phase now playing.
  always_comb begin
    cur_len = phase_length;
    if (short_long_pattern) begin
      if (phases_left == 6'd1) begin
        cur_len = LONG_PHASE_MS;
      end else if (phases_left == 6'd2 || phases_left == 6'd3) begin
        cur_len = SHORT_PHASE_MS;
      end
    end
  end

  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 16'd1;
  assign play_ok     = (sound_mode != '0);

  // State update for the buffered word.
  always_comb begin
    phases_left_next        = phases_left;
    elapsed_ms_next         = elapsed_ms;
    sounding_next           = sounding;
    phase_length_next       = phase_length;
    short_long_pattern_next = short_long_pattern;
    unique case (item.mode)
      MODE_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (phases_left != '0) begin
          if (elapsed_inc >= cur_len) begin
            sounding_next    = !sounding;
            elapsed_ms_next  = '0;
            phases_left_next = phases_left - 6'd1;
          end
        end else begin
          sounding_next = 1'b0;
        end
      end
      MODE_PLAY_COUNT: begin
        if (play_ok && item.beep_count != '0) begin
          short_long_pattern_next = 1'b0;
          phases_left_next        = {item.beep_count, 1'b0} - 6'd1;
          phase_length_next       = item.phase_ms;
          sounding_next           = 1'b1;
          elapsed_ms_next         = '0;
        end
      end
      MODE_PLAY_SL: begin
        if (play_ok) begin
          short_long_pattern_next = 1'b1;
          phases_left_next        = SL_PHASES_START;
          sounding_next           = 1'b1;
          elapsed_ms_next         = '0;
        end
      end
      MODE_UNUSED: begin
        // No meaning; the state stays as it is.
      end
      default: begin
      end
    endcase
  end

  // Pattern state, updated as each word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phases_left        <= '0;
      elapsed_ms         <= '0;
      sounding           <= 1'b0;
      phase_length       <= DEFAULT_PHASE_MS;
      short_long_pattern <= 1'b0;
    end else if (item_advance) begin
      phases_left        <= phases_left_next;
      elapsed_ms         <= elapsed_ms_next;
      sounding           <= sounding_next;
      phase_length       <= phase_length_next;
      short_long_pattern <= short_long_pattern_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_advance) begin
      out_buzzer <= sounding_next;
      out_busy   <= (phases_left_next != '0);
    end
  end

  // The short-long pattern never has more than its starting phase count left.
  a_sl_phases: assert property (@(posedge clk) disable iff (rst)
    short_long_pattern |-> (phases_left <= SL_PHASES_START))
    else $error("short-long pattern with too many phases left");

  // An accepted word is in the input register on the next cycle.
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> item_valid)
    else $error("accepted word lost from input register");

  // A buffered word that cannot move holds its kind.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_advance) |=> (item_valid && $stable(item.mode)))
    else $error("stalled input word changed");

  // The busy flag of a new output word matches the phase count.
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    item_advance |=> (out_busy == (phases_left != '0)))
    else $error("busy output disagrees with phase count");

endmodule
